// ===== sv/mfd_pkg.sv =====
// shared types, constants and codes of the motor feedback frame decoder
package mfd_pkg;

  localparam int unsigned PULSES_PER_TURN_DEF = 4096;

  localparam int unsigned FRAME_LEN   = 7;
  localparam int unsigned COUNT_W     = $clog2(FRAME_LEN);
  localparam logic [7:0]  HEADER      = 8'hA5;
  localparam logic [7:0]  CODE_SPEED  = 8'h02;
  localparam logic [7:0]  CODE_PULSE  = 8'h04;
  localparam int unsigned ANGLE_SCALE = 360;

  localparam int unsigned READ_W  = 16;
  localparam int unsigned SPEED_W = 17;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned ANGLE_W = 29;
  localparam int unsigned DIFF_W  = 19;

  // angle datapath: |total| * 360 < 2**PROD_W, reciprocal fits PROD_W + 2 bits
  localparam int unsigned PROD_W  = 40;
  localparam int unsigned PART_W  = PROD_W / 2;
  localparam int unsigned RECIP_W = PROD_W + 2;
  localparam int unsigned RPART_W = RECIP_W / 2;
  localparam int unsigned PP_W    = PART_W + RPART_W;
  localparam int unsigned SUM_W   = PP_W + RPART_W + 1;
  localparam int unsigned FIN_W   = SUM_W + PART_W + 3;

  localparam int unsigned IN_W  = 16;
  localparam int unsigned OUT_W = 224;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef enum logic [1:0] {
    FRAME_SPEED = 2'd0,
    FRAME_PULSE = 2'd1,
    FRAME_OTHER = 2'd2
  } frame_kind_t;

  typedef enum logic [1:0] {
    REG_LEFT_NEGATIVE  = 2'd0,
    REG_RIGHT_NEGATIVE = 2'd1,
    REG_LOCK_FOLLOW    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic left_negative;
    logic right_negative;
    logic lock_follow;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{left_negative: 1'b0, right_negative: 1'b1, lock_follow: 1'b1};

  typedef struct packed {
    logic done;
    logic last_slot;
  } dec_status_t;

  typedef struct packed {
    logic busy;
    logic valid;
  } ang_status_t;

endpackage

// ===== sv/motor_feedback_frame_decoder.sv =====
// top level of the motor feedback frame decoder: config registers, stream ports
//
// Input stream (s_axis): one received UART byte per request, plus the two zero
// requests; bytes may come every cycle. The block hunts for the 0xA5 header,
// gathers 7-byte frames and checks the sum of bytes 0 to 5 against byte 6.
// Output stream (m_axis): one result per frame with a good sum, none for bad
// frames. Speeds, totals and locks hold between frames.
// The result shows on m_axis_tvalid after the byte that completes the frame
// is taken, through the done register, the angle pipeline (magnitude times
// 360, reciprocal partial products, two sum stages) and the output register.
// Throughput: one byte per cycle. Only the frame's last byte can be held off,
// while the previous result is still in the angle pipeline or waits at the
// output; with frames of 7 bytes and a ready receiver no byte ever waits.
// A stalled receiver keeps the result on m_axis_tdata; bytes that do not end
// a frame are still taken, zero requests still latch.
// Reset clears the frame buffer, totals, locks, speeds, pending zero requests
// and loads the register defaults (left 0, right negated, lock follows).
// The APB port has left_negative at 0x0, right_negative at 0x4 and lock_follow
// at 0x8, bit 0 each; write them only while no frame is in flight.
module motor_feedback_frame_decoder #(
  parameter int unsigned PULSES_PER_TURN = mfd_pkg::PULSES_PER_TURN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // rx_byte [7:0], zero_left [8], zero_right [9], zero fill [15:10]
  input  logic [mfd_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // frame_kind [1:0], left_speed [18:2], right_speed [35:19],
  // left_total [67:36], right_total [99:68], left_angle [128:100],
  // right_angle [157:129], left_lock [189:158], right_lock [221:190],
  // zero fill [223:222]
  output logic [mfd_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mfd_pkg::APB_AW-1:0] paddr,
  input  logic [mfd_pkg::APB_DW-1:0] pwdata,
  output logic [mfd_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  mfd_pkg::cfg_t        cfg;
  mfd_pkg::reg_index_t  reg_index;
  logic                 cfg_write;

  mfd_pkg::dec_status_t dec_status;
  mfd_pkg::ang_status_t ang_status;
  mfd_pkg::frame_kind_t kind;
  mfd_pkg::speed_t      speed [2];
  mfd_pkg::pos_t        total [2];
  mfd_pkg::pos_t        lock [2];
  mfd_pkg::angle_t      angle [2];

  logic                 in_accept;
  logic                 pipe_busy;
  logic                 out_valid;

  assign pready    = 1'b1;
  assign reg_index = mfd_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= mfd_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        mfd_pkg::REG_LEFT_NEGATIVE:  cfg.left_negative  <= pwdata[0];
        mfd_pkg::REG_RIGHT_NEGATIVE: cfg.right_negative <= pwdata[0];
        mfd_pkg::REG_LOCK_FOLLOW:    cfg.lock_follow    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      mfd_pkg::REG_LEFT_NEGATIVE:  prdata = mfd_pkg::APB_DW'(cfg.left_negative);
      mfd_pkg::REG_RIGHT_NEGATIVE: prdata = mfd_pkg::APB_DW'(cfg.right_negative);
      mfd_pkg::REG_LOCK_FOLLOW:    prdata = mfd_pkg::APB_DW'(cfg.lock_follow);
      default:                     prdata = '0;
    endcase
  end

  // one result in flight at a time; only a frame's last byte waits for it
  assign pipe_busy = dec_status.done | ang_status.busy | ang_status.valid |
                     (out_valid & ~m_axis_tready);
  assign s_axis_tready = ~(dec_status.last_slot & pipe_busy);
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  mfd_decoder #(
    .PULSES_PER_TURN(PULSES_PER_TURN)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .rx_byte   (s_axis_tdata[7:0]),
    .zero_left (s_axis_tdata[8]),
    .zero_right(s_axis_tdata[9]),
    .cfg       (cfg),
    .status    (dec_status),
    .kind      (kind),
    .speed     (speed),
    .total     (total),
    .lock      (lock)
  );

  mfd_angle #(
    .PULSES_PER_TURN(PULSES_PER_TURN)
  ) u_angle (
    .clk   (clk),
    .rst   (rst),
    .start (dec_status.done),
    .total (total),
    .angle (angle),
    .status(ang_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ang_status.valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, lock[1], lock[0], angle[1], angle[0],
                          total[1], total[0], speed[1], speed[0], kind};

`ifndef SYNTHESIS
  a_single_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0({dec_status.done, ang_status.busy, ang_status.valid, out_valid}))
    else $error("more than one frame result in flight");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ang_status.valid))
    else $error("output raised without a finished angle");
`endif

endmodule

// ===== sv/mfd_decoder.sv =====
// frame assembly, sum check, speed decode and encoder unwrap state
module mfd_decoder #(
  parameter int unsigned PULSES_PER_TURN = mfd_pkg::PULSES_PER_TURN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                rx_byte,
  input  logic                      zero_left,
  input  logic                      zero_right,
  input  mfd_pkg::cfg_t             cfg,
  output mfd_pkg::dec_status_t      status,
  output mfd_pkg::frame_kind_t      kind,
  output mfd_pkg::speed_t           speed [2],
  output mfd_pkg::pos_t             total [2],
  output mfd_pkg::pos_t             lock [2]
);

  localparam int unsigned DW = mfd_pkg::DIFF_W;
  localparam int unsigned RW = mfd_pkg::READ_W;
  localparam int unsigned PW = mfd_pkg::POS_W;
  localparam int unsigned CW = mfd_pkg::COUNT_W;
  localparam logic signed [DW-1:0] TURN = DW'(PULSES_PER_TURN);
  localparam logic signed [DW-1:0] HALF = DW'(PULSES_PER_TURN / 2);

  logic [7:0]          fb [mfd_pkg::FRAME_LEN-1];
  logic [CW-1:0]       count;
  logic [RW-1:0]       last_reading [2];
  logic [1:0]          pending;
  logic                done;

  logic                restart;
  logic [CW-1:0]       eff_count;
  logic                complete;
  logic [7:0]          sum;
  logic                good;
  logic                is_speed;
  logic                is_pulse;
  logic [1:0]          pend;
  logic [1:0]          neg;
  logic [RW-1:0]       reading [2];
  mfd_pkg::speed_t     raw_speed [2];
  mfd_pkg::speed_t     speed_new [2];
  logic signed [DW-1:0] diff [2];
  logic signed [DW-1:0] adj [2];
  mfd_pkg::pos_t       total_sum [2];

  always_comb begin
    restart   = (rx_byte == mfd_pkg::HEADER) && (fb[0] != mfd_pkg::HEADER);
    eff_count = restart ? '0 : count;
    complete  = (eff_count == CW'(mfd_pkg::FRAME_LEN - 1));
    sum = '0;
    for (int i = 0; i < mfd_pkg::FRAME_LEN - 1; i++) begin
      sum = sum + fb[i];
    end
    good     = complete && (fb[0] == mfd_pkg::HEADER) && (sum == rx_byte);
    is_speed = (fb[1] == mfd_pkg::CODE_SPEED);
    is_pulse = (fb[1] == mfd_pkg::CODE_PULSE);
    pend     = pending | {zero_right, zero_left};
    neg      = {cfg.right_negative, cfg.left_negative};
    for (int m = 0; m < 2; m++) begin
      reading[m]   = {fb[2 + 2 * m], fb[3 + 2 * m]};
      raw_speed[m] = {reading[m][RW-1], reading[m]};
      speed_new[m] = neg[m] ? -raw_speed[m] : raw_speed[m];
      diff[m] = $signed({3'b000, reading[m]}) - $signed({3'b000, last_reading[m]});
      priority if (diff[m] > HALF) begin
        adj[m] = diff[m] - TURN;
      end else if (diff[m] < -HALF) begin
        adj[m] = diff[m] + TURN;
      end else begin
        adj[m] = diff[m];
      end
      total_sum[m] = total[m] + {{(PW - DW){adj[m][DW-1]}}, adj[m]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mfd_pkg::FRAME_LEN - 1; i++) begin
        fb[i] <= '0;
      end
      count   <= '0;
      pending <= '0;
      done    <= 1'b0;
      kind    <= mfd_pkg::FRAME_SPEED;
      for (int m = 0; m < 2; m++) begin
        last_reading[m] <= '0;
        total[m]        <= '0;
        lock[m]         <= '0;
        speed[m]        <= '0;
      end
    end else begin
      done <= 1'b0;
      if (accept) begin
        pending <= pend;
        if (complete) begin
          count <= '0;
        end else begin
          count         <= eff_count + CW'(1);
          fb[eff_count] <= rx_byte;
        end
        if (good) begin
          done <= 1'b1;
          priority if (is_speed) begin
            kind <= mfd_pkg::FRAME_SPEED;
            for (int m = 0; m < 2; m++) begin
              speed[m] <= speed_new[m];
            end
          end else if (is_pulse) begin
            kind    <= mfd_pkg::FRAME_PULSE;
            pending <= '0;
            for (int m = 0; m < 2; m++) begin
              last_reading[m] <= reading[m];
              total[m]        <= pend[m] ? '0 : total_sum[m];
              lock[m]         <= pend[m] ? '0 : (cfg.lock_follow ? total_sum[m] : lock[m]);
            end
          end else begin
            kind <= mfd_pkg::FRAME_OTHER;
          end
        end
      end
    end
  end

  assign status.done      = done;
  assign status.last_slot = (count == CW'(mfd_pkg::FRAME_LEN - 1));

`ifndef SYNTHESIS
  a_done_clears_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (count == '0))
    else $error("frame result without cleared byte count");

  a_total_moves_on_done: assert property (@(posedge clk) disable iff (rst)
    (!$stable(total[0]) || !$stable(total[1])) |-> done)
    else $error("pulse total changed without a good frame");

  a_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("frame result without an accepted byte");
`endif

endmodule

// ===== sv/mfd_angle.sv =====
// pipelined angle unit: trunc(total * 360 / pulses per turn) by reciprocal product
module mfd_angle #(
  parameter int unsigned PULSES_PER_TURN = mfd_pkg::PULSES_PER_TURN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mfd_pkg::pos_t        total [2],
  output mfd_pkg::angle_t      angle [2],
  output mfd_pkg::ang_status_t status
);

  localparam int unsigned PW   = mfd_pkg::PROD_W;
  localparam int unsigned HW   = mfd_pkg::PART_W;
  localparam int unsigned RHW  = mfd_pkg::RPART_W;
  localparam int unsigned PPW  = mfd_pkg::PP_W;
  localparam int unsigned SW   = mfd_pkg::SUM_W;
  localparam int unsigned FW   = mfd_pkg::FIN_W;
  localparam int unsigned AW   = mfd_pkg::ANGLE_W;
  localparam int unsigned LOGD = $clog2(PULSES_PER_TURN);
  localparam int unsigned SH   = PW + LOGD;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(PULSES_PER_TURN) - 64'd1) / 64'(PULSES_PER_TURN);
  localparam logic [RHW-1:0] RECIP_LO = RECIP[RHW-1:0];
  localparam logic [RHW-1:0] RECIP_HI = RECIP[2*RHW-1:RHW];

  logic            v_a, v_b, v_c, v_d;
  logic [1:0]      sign_a, sign_b, sign_c;
  logic [PW-1:0]   prod_a [2];
  logic [PPW-1:0]  pp_ll [2];
  logic [PPW-1:0]  pp_lh [2];
  logic [PPW-1:0]  pp_hl [2];
  logic [PPW-1:0]  pp_hh [2];
  logic [SW-1:0]   s_lo [2];
  logic [SW-1:0]   s_hi [2];

  logic [31:0]     mag [2];
  logic [FW-1:0]   fin [2];
  logic [AW-1:0]   quo [2];

  always_comb begin
    for (int m = 0; m < 2; m++) begin
      mag[m] = total[m][31] ? 32'(-total[m]) : 32'(total[m]);
      fin[m] = FW'(s_lo[m]) + (FW'(s_hi[m]) << HW);
      quo[m] = fin[m][SH +: AW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      v_a <= start;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    sign_a <= {total[1][31], total[0][31]};
    sign_b <= sign_a;
    sign_c <= sign_b;
    for (int m = 0; m < 2; m++) begin
      prod_a[m] <= PW'(mag[m]) * PW'(mfd_pkg::ANGLE_SCALE);
      pp_ll[m]  <= PPW'(prod_a[m][HW-1:0]) * PPW'(RECIP_LO);
      pp_lh[m]  <= PPW'(prod_a[m][HW-1:0]) * PPW'(RECIP_HI);
      pp_hl[m]  <= PPW'(prod_a[m][PW-1:HW]) * PPW'(RECIP_LO);
      pp_hh[m]  <= PPW'(prod_a[m][PW-1:HW]) * PPW'(RECIP_HI);
      s_lo[m]   <= SW'(pp_ll[m]) + (SW'(pp_lh[m]) << RHW);
      s_hi[m]   <= SW'(pp_hl[m]) + (SW'(pp_hh[m]) << RHW);
      if (v_c) begin
        angle[m] <= sign_c[m] ? AW'(-quo[m]) : quo[m];
      end
    end
  end

  assign status.busy  = v_a | v_b | v_c;
  assign status.valid = v_d;

endmodule

// ===== dv/motor_feedback_frame_decoder_test.sv =====
// self-checking stream testbench for the motor feedback frame decoder
`timescale 1ns / 100ps

module motor_feedback_frame_decoder_test;
  import mfd_pkg::*;

  localparam int TURN = 4096;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS = 214;
  localparam int PHASES = 5;

  typedef struct packed {
    pos_t        right_lock;
    pos_t        left_lock;
    angle_t      right_angle;
    angle_t      left_angle;
    pos_t        right_total;
    pos_t        left_total;
    speed_t      right_speed;
    speed_t      left_speed;
    frame_kind_t kind;
  } report_t;

  typedef struct {
    logic [7:0]  lead;
    logic [7:0]  code;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [7:0]  sum_err;
    logic [1:0]  zmask;
    bit          check;
    report_t     want;
  } row_t;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // rx_byte [7:0], zero_left [8], zero_right [9]
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // frame_kind, speeds, totals, angles, locks, left before right
  logic [OUT_W-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  motor_feedback_frame_decoder #(.PULSES_PER_TURN(TURN)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // decoder state as seen from the byte stream
  logic [7:0]  frame_buf [FRAME_LEN];
  int          fill;
  logic [15:0] last_rd [2];
  logic [31:0] total [2];
  logic [31:0] lock_pos [2];
  speed_t      speed_now [2];
  bit          zero_due [2];
  cfg_t        cfg_now;

  report_t frame_reports_due [$];
  int n_items;
  int n_checked;
  int failures;
  int kind_seen [3];
  int burst_left;
  int hold_requests;
  int hold_started;
  int hold_left;
  int mode_left;
  ready_mode_t ready_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic speed_t speed_of(logic [7:0] hi, logic [7:0] lo, bit neg);
    int v;
    v = $signed({hi, lo});
    if (neg) v = -v;
    return v[SPEED_W-1:0];
  endfunction

  function automatic angle_t angle_of(logic [31:0] t);
    longint p;
    p = longint'($signed(t)) * 360 / longint'(TURN);
    return p[ANGLE_W-1:0];
  endfunction

  function automatic void unwrap_count(int m, logic [15:0] rd);
    int d;
    d = int'(rd) - int'(last_rd[m]);
    last_rd[m] = rd;
    if (d > TURN / 2) d -= TURN;
    else if (d < -(TURN / 2)) d += TURN;
    total[m] = total[m] + d;
    if (cfg_now.lock_follow) lock_pos[m] = total[m];
    if (zero_due[m]) begin
      zero_due[m] = 1'b0;
      total[m] = '0;
      lock_pos[m] = '0;
    end
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input bit zl, input bit zr,
                                     output report_t r);
    logic [7:0] sum;
    logic [7:0] f [FRAME_LEN];
    r = '0;
    if (zl) zero_due[0] = 1'b1;
    if (zr) zero_due[1] = 1'b1;
    if (b == HEADER && frame_buf[0] != HEADER) fill = 0;
    frame_buf[fill] = b;
    fill++;
    if (fill < FRAME_LEN) return 1'b0;
    f = frame_buf;
    fill = 0;
    foreach (frame_buf[i]) frame_buf[i] = '0;
    sum = f[0] + f[1] + f[2] + f[3] + f[4] + f[5];
    if (f[0] != HEADER || sum != f[6]) return 1'b0;
    if (f[1] == CODE_SPEED) begin
      r.kind = FRAME_SPEED;
      speed_now[0] = speed_of(f[2], f[3], cfg_now.left_negative);
      speed_now[1] = speed_of(f[4], f[5], cfg_now.right_negative);
    end else if (f[1] == CODE_PULSE) begin
      r.kind = FRAME_PULSE;
      unwrap_count(0, {f[2], f[3]});
      unwrap_count(1, {f[4], f[5]});
    end else begin
      r.kind = FRAME_OTHER;
    end
    r.left_speed = speed_now[0];
    r.right_speed = speed_now[1];
    r.left_total = total[0];
    r.right_total = total[1];
    r.left_angle = angle_of(total[0]);
    r.right_angle = angle_of(total[1]);
    r.left_lock = lock_pos[0];
    r.right_lock = lock_pos[1];
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_word();
    if ($urandom_range(0, 6) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // small moves four times in ten, some right at the half-turn boundary, some far off
  function automatic logic [15:0] next_reading(logic [15:0] prev);
    int step;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: step = $urandom_range(0, 200) - 100;
      4, 5: step = TURN / 2 - 1 + $urandom_range(0, 2);
      6: step = $urandom_range(TURN / 2 + 2, 3 * TURN);
      default: step = $urandom;
    endcase
    if ($urandom_range(0, 1) != 0) step = -step;
    return prev + step[15:0];
  endfunction

  function automatic string show(report_t r);
    return $sformatf("kind=%0d speed=%0d/%0d total=%0d/%0d angle=%0d/%0d lock=%0d/%0d",
                     r.kind, r.left_speed, r.right_speed, r.left_total, r.right_total,
                     r.left_angle, r.right_angle, r.left_lock, r.right_lock);
  endfunction

  function automatic void note(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit zl, input bit zr,
                           input bit typed, input report_t typed_want);
    report_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, zr, zl, b};
    do @(posedge clk); while (!s_axis_tready);
    n_items++;
    if (decode_byte(b, zl, zr, r)) frame_reports_due.push_back(typed ? typed_want : r);
  endtask

  task automatic send_frame(input logic [7:0] hdr, input logic [7:0] code,
                            input logic [15:0] w0, input logic [15:0] w1,
                            input logic [7:0] sum_err, input logic [1:0] zlast, input int n,
                            input bit check, input report_t want);
    logic [7:0] fb [FRAME_LEN];
    logic [7:0] sum;
    bit zl;
    bit zr;
    fb[0] = hdr;
    fb[1] = code;
    fb[2] = w0[15:8];
    fb[3] = w0[7:0];
    fb[4] = w1[15:8];
    fb[5] = w1[7:0];
    sum = fb[0] + fb[1] + fb[2] + fb[3] + fb[4] + fb[5];
    fb[6] = sum ^ sum_err;
    for (int i = 0; i < n; i++) begin
      if (i == FRAME_LEN - 1) begin
        send_byte(fb[i], zlast[0], zlast[1], check, want);
      end else begin
        zl = !check && $urandom_range(0, 47) == 0;
        zr = !check && $urandom_range(0, 47) == 0;
        send_byte(fb[i], zl, zr, 1'b0, want);
      end
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(APB_DW-1){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (frame_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: own ready pattern, plus one long hold on request
  always @(posedge clk) begin
    if (hold_started != hold_requests) begin
      hold_started <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(16, 160);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        READY_ALWAYS: m_axis_tready <= 1'b1;
        READY_COIN: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    report_t seen;
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = report_t'(m_axis_tdata[$bits(report_t)-1:0]);
      kind_seen[seen.kind]++;
      if (frame_reports_due.size() == 0) begin
        note($sformatf("result with none due at %0t: %s", $time, show(seen)));
      end else begin
        want = frame_reports_due.pop_front();
        n_checked++;
        if (seen !== want)
          note($sformatf("mismatch at %0t\n  expected %s\n  actual   %s",
                         $time, show(want), show(seen)));
      end
    end
  end

  initial begin
    cfg_t plan [PHASES];
    row_t rows [$];
    int pick;
    int target;
    logic [7:0] code;
    logic [7:0] hdr;
    logic [15:0] w0;
    logic [15:0] w1;

    foreach (frame_buf[i]) frame_buf[i] = '0;
    fill = 0;
    for (int m = 0; m < 2; m++) begin
      last_rd[m] = '0;
      total[m] = '0;
      lock_pos[m] = '0;
      speed_now[m] = '0;
      zero_due[m] = 1'b0;
    end
    cfg_now = CFG_RESET;
    plan = '{CFG_RESET, cfg_t'(3'b100), cfg_t'(3'b111), cfg_t'(3'b000), cfg_t'(3'b010)};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // speed extremes after reset, pulse with unwrap and zero, bad sum, unknown code
    rows.push_back(row_t'{lead: 8'hFF, code: CODE_SPEED, w0: 16'h7FFF, w1: 16'h8000,
                          sum_err: 8'h00, zmask: 2'b00, check: 1'b1,
                          want: report_t'{kind: FRAME_SPEED, left_speed: 32767,
                                          right_speed: 32768, default: '0}});
    rows.push_back(row_t'{lead: 8'h00, code: CODE_PULSE, w0: 16'h0800, w1: 16'hF000,
                          sum_err: 8'h00, zmask: 2'b10, check: 1'b1,
                          want: report_t'{kind: FRAME_PULSE, left_speed: 32767,
                                          right_speed: 32768, left_total: 2048,
                                          left_angle: 180, left_lock: 2048, default: '0}});
    rows.push_back(row_t'{lead: 8'h00, code: CODE_PULSE, w0: 16'hFFFF, w1: 16'h0000,
                          sum_err: 8'h01, zmask: 2'b01, check: 1'b0, want: '0});
    rows.push_back(row_t'{lead: 8'h5A, code: 8'hFF, w0: 16'hFFFF, w1: 16'hFFFF,
                          sum_err: 8'h00, zmask: 2'b00, check: 1'b1,
                          want: report_t'{kind: FRAME_OTHER, left_speed: 32767,
                                          right_speed: 32768, left_total: 2048,
                                          left_angle: 180, left_lock: 2048, default: '0}});
    foreach (rows[i]) begin
      send_byte(rows[i].lead, 1'b0, 1'b0, 1'b0, '0);
      send_frame(HEADER, rows[i].code, rows[i].w0, rows[i].w1, rows[i].sum_err,
                 rows[i].zmask, FRAME_LEN, rows[i].check, rows[i].want);
    end

    target = n_items;
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        write_reg(REG_LEFT_NEGATIVE, plan[p].left_negative);
        write_reg(REG_RIGHT_NEGATIVE, plan[p].right_negative);
        write_reg(REG_LOCK_FOLLOW, plan[p].lock_follow);
        cfg_now = plan[p];
      end
      target += PHASE_ITEMS;
      while (n_items < target) begin
        if (p == 1 && hold_requests == 0 && n_items >= target - PHASE_ITEMS / 2)
          hold_requests++;
        pick = $urandom_range(0, 99);
        code = (pick % 5 < 2) ? CODE_PULSE : (pick % 5 < 4) ? CODE_SPEED : 8'($urandom);
        w0 = pick_word();
        w1 = pick_word();
        if (code == CODE_PULSE) begin
          w0 = next_reading(last_rd[0]);
          w1 = next_reading(last_rd[1]);
        end
        if (pick < 78) begin
          send_frame(HEADER, code, w0, w1, 8'h00,
                     {$urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0},
                     FRAME_LEN, 1'b0, '0);
        end else if (pick < 86) begin
          send_frame(HEADER, code, w0, w1, 8'h00, 2'b00, $urandom_range(1, FRAME_LEN - 1),
                     1'b0, '0);
        end else if (pick < 94) begin
          repeat ($urandom_range(1, 5))
            send_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0, 1'b0, '0);
        end else begin
          hdr = (pick % 2 == 0) ? 8'($urandom) : HEADER;
          send_frame(hdr, code, w0, w1, (hdr == HEADER) ? $urandom_range(1, 255) : 8'h00,
                     2'b00, FRAME_LEN, 1'b0, '0);
        end
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end

    $display("covered %0d input bytes, %0d frame results checked (%0d speed, %0d pulse, %0d other)",
             n_items, n_checked, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("over %0d register settings and one %0d-cycle output hold; %0d checks failed",
             PHASES, HOLD_CYCLES, failures);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timed out with %0d results still due", frame_reports_due.size());
    $display("FAIL");
    $finish;
  end

endmodule
